@@ design/ksr_pkg.sv @@
// Shared types, keymaps and key translation for the keyboard scan block.
`default_nettype none

package ksr_pkg;

   localparam int INPUT_ROWS  = 4;
   localparam int INPUT_ROW_W = 16;
   localparam int MAP_SIZE    = 50;
   localparam int MAP_IDX_W   = $clog2(MAP_SIZE);
   localparam int KEY_IDX_W   = 8;

   localparam logic [7:0] CODE_FLAG = 8'h80;
   localparam logic [7:0] CODE_NONE = 8'h00;

   typedef struct packed {
      logic [INPUT_ROW_W-1:0] row0_keys;
      logic [INPUT_ROW_W-1:0] row1_keys;
      logic [INPUT_ROW_W-1:0] row2_keys;
      logic [INPUT_ROW_W-1:0] row3_keys;
      logic [1:0]             shift_bits;
      logic [1:0]             ctrl_bits;
      logic                   reset_button;
      logic                   clear_button;
   } req_type;

   typedef struct packed {
      logic [7:0] port_a_value;
      logic       key_strobe;
      logic       cpu_reset_hold;
      logic       pia_reset_pulse;
      logic       clear_screen_pulse;
      logic       video_writes_ignored;
   } rsp_type;

   typedef logic [7:0] keymap_type [MAP_SIZE];

   localparam keymap_type MAP_PLAIN = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h3B, 8'h27,
      8'h2C, 8'h2E, 8'h2F, 8'h5C, 8'h41, 8'h42, 8'h43, 8'h44,
      8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
      8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
      8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h0D, 8'h5F,
      8'h20, 8'h1B
   };

   localparam keymap_type MAP_SHIFT = '{
      8'h29, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26,
      8'h2A, 8'h28, 8'h5F, 8'h2B, 8'h5B, 8'h5D, 8'h3A, 8'h22,
      8'h3C, 8'h3E, 8'h3F, 8'h5C, 8'h41, 8'h42, 8'h43, 8'h44,
      8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
      8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
      8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h0D, 8'h5F,
      8'h20, 8'h1B
   };

   localparam keymap_type MAP_CTRL = '{
      8'h30, 8'h31, 8'h00, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
      8'h38, 8'h39, 8'h1F, 8'h3D, 8'h1B, 8'h1D, 8'h3B, 8'h27,
      8'h2C, 8'h2E, 8'h2F, 8'h1C, 8'h01, 8'h02, 8'h03, 8'h04,
      8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C,
      8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
      8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h0D, 8'h5F,
      8'h00, 8'h1B
   };

   function automatic logic [7:0] key_translate(input logic [KEY_IDX_W-1:0] idx,
                                                input logic ctrl,
                                                input logic shift);
      logic [7:0] code;
      code = CODE_NONE;
      if (idx < KEY_IDX_W'(MAP_SIZE)) begin
         if (ctrl) begin
            code = MAP_CTRL[idx[MAP_IDX_W-1:0]];
         end else if (shift) begin
            code = MAP_SHIFT[idx[MAP_IDX_W-1:0]];
         end else begin
            code = MAP_PLAIN[idx[MAP_IDX_W-1:0]];
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

@@ design/ksr_lane.sv @@
// One row lane: previous scan register and highest newly pressed key in the row.
`default_nettype none

module ksr_lane #(
   parameter int KEYS_PER_ROW = 16,
   parameter int BIT_W        = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic [KEYS_PER_ROW-1:0] row_now,
   output logic                         hit,
   output logic [BIT_W-1:0]             hit_bit
);

   logic [KEYS_PER_ROW-1:0] prev_scan_ff;
   logic [KEYS_PER_ROW-1:0] prev_scan_in;
   logic [KEYS_PER_ROW-1:0] fresh;

   assign fresh        = row_now & ~prev_scan_ff;
   assign prev_scan_in = advance ? row_now : prev_scan_ff;

   always_comb begin
      hit     = 1'b0;
      hit_bit = '0;
      for (int b = 0; b < KEYS_PER_ROW; b++) begin
         if (fresh[b]) begin
            hit     = 1'b1;
            hit_bit = BIT_W'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_scan_ff <= '0;
      end else begin
         prev_scan_ff <= prev_scan_in;
      end
   end

endmodule

`default_nettype wire

@@ design/ksr_merge.sv @@
// Merge of lane hits into the winning key, keymap lookup and pushbutton edges.
`default_nettype none

module ksr_merge #(
   parameter int ROW_COUNT    = 4,
   parameter int KEYS_PER_ROW = 16,
   parameter int BIT_W        = 4,
   parameter int IDX_W        = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire ksr_pkg::req_type                 req,
   input  wire logic [ROW_COUNT-1:0]             lane_hit,
   input  wire logic [ROW_COUNT-1:0][BIT_W-1:0]  lane_bit,
   output ksr_pkg::rsp_type                      result
);

   logic             reset_held_ff;
   logic             reset_held_in;
   logic             clear_held_ff;
   logic             clear_held_in;
   logic             found;
   logic [IDX_W-1:0] win;
   logic [7:0]       code;

   always_comb begin
      found = 1'b0;
      win   = '0;
      for (int r = 0; r < ROW_COUNT; r++) begin
         if (lane_hit[r]) begin
            found = 1'b1;
            win   = IDX_W'(r * KEYS_PER_ROW) + IDX_W'(lane_bit[r]);
         end
      end
   end

   always_comb begin
      code = ksr_pkg::CODE_NONE;
      if (found) begin
         code = ksr_pkg::key_translate(ksr_pkg::KEY_IDX_W'(win),
                                       |req.ctrl_bits, |req.shift_bits);
      end
   end

   assign reset_held_in = advance ? req.reset_button : reset_held_ff;
   assign clear_held_in = advance ? req.clear_button : clear_held_ff;

   always_comb begin
      result.port_a_value         = code | ksr_pkg::CODE_FLAG;
      result.key_strobe           = found;
      result.cpu_reset_hold       = req.reset_button;
      result.pia_reset_pulse      = req.reset_button & ~reset_held_ff;
      result.clear_screen_pulse   = req.clear_button & ~clear_held_ff;
      result.video_writes_ignored = req.clear_button;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_held_ff <= 1'b0;
         clear_held_ff <= 1'b0;
      end else begin
         reset_held_ff <= reset_held_in;
         clear_held_ff <= clear_held_in;
      end
   end

endmodule

`default_nettype wire

@@ design/keyboard_scan_rollover.sv @@
// Keyboard scan with rollover: row lanes, merge stage and two-entry output stage.
//
// Each request beat is one keyboard poll and yields exactly one response beat
// from the main register, via the skid entry if the output stalls. One poll is
// taken every clock cycle while the skid entry is empty: the row lanes find the
// newest key of each row in parallel, the merge stage picks the highest one and
// looks it up in the keymaps, all combinationally. Both entries let a poll be
// taken while one result waits; requests stall only once both are full.
`default_nettype none

module keyboard_scan_rollover #(
   parameter int ROW_COUNT    = 4,
   parameter int KEYS_PER_ROW = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ksr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ksr_pkg::rsp_type      rsp_data
);

   localparam int KEY_COUNT = ROW_COUNT * KEYS_PER_ROW;
   localparam int BIT_W     = (KEYS_PER_ROW > 1) ? $clog2(KEYS_PER_ROW) : 1;
   localparam int IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   logic                                         req_fire;
   logic [ksr_pkg::INPUT_ROWS-1:0][ksr_pkg::INPUT_ROW_W-1:0] in_rows;
   logic [ROW_COUNT-1:0]                         lane_hit;
   logic [ROW_COUNT-1:0][BIT_W-1:0]              lane_bit;
   ksr_pkg::rsp_type                             result;

   ksr_pkg::rsp_type out_ff;
   ksr_pkg::rsp_type out_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   ksr_pkg::rsp_type skid_ff;
   ksr_pkg::rsp_type skid_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;

   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign in_rows[0] = req_data.row0_keys;
   assign in_rows[1] = req_data.row1_keys;
   assign in_rows[2] = req_data.row2_keys;
   assign in_rows[3] = req_data.row3_keys;

   for (genvar r = 0; r < ROW_COUNT; r++) begin : g_lane
      logic [KEYS_PER_ROW-1:0] row_now;

      if (r < ksr_pkg::INPUT_ROWS) begin : g_wired
         assign row_now = KEYS_PER_ROW'(in_rows[r]);
      end else begin : g_open
         assign row_now = '0;
      end

      ksr_lane #(
         .KEYS_PER_ROW(KEYS_PER_ROW),
         .BIT_W       (BIT_W)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .advance(req_fire),
         .row_now(row_now),
         .hit    (lane_hit[r]),
         .hit_bit(lane_bit[r])
      );
   end

   ksr_merge #(
      .ROW_COUNT   (ROW_COUNT),
      .KEYS_PER_ROW(KEYS_PER_ROW),
      .BIT_W       (BIT_W),
      .IDX_W       (IDX_W)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .advance (req_fire),
      .req     (req_data),
      .lane_hit(lane_hit),
      .lane_bit(lane_bit),
      .result  (result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         // hold the new beat behind the stalled one
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

@@ design/ksr_checker.sv @@
// Port checker for the keyboard scan block and its bind to the top level.
`default_nettype none

module ksr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ksr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_idle_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.key_strobe |-> rsp_data.port_a_value == ksr_pkg::CODE_FLAG)
      else $error("key code present without strobe");

   a_reset_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pia_reset_pulse |-> rsp_data.cpu_reset_hold)
      else $error("reset pulse without held reset");

   a_clear_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clear_screen_pulse |-> rsp_data.video_writes_ignored)
      else $error("clear pulse without held clear");

endmodule

bind keyboard_scan_rollover ksr_checker u_ksr_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire

@@ tb/keyboard_scan_rollover_tb.sv @@
// Testbench for keyboard_scan_rollover: directed and random polls checked against a scan predictor.
`timescale 1ns / 1ps

module keyboard_scan_rollover_tb;

   localparam int RANDOM_POLLS = 700;
   localparam int CALM_POLLS   = 100;
   localparam int HANG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   // Keymaps, key index 0 leftmost.
   localparam logic [399:0] PLAIN_KEYS =
      {"0123456789-=[];',./\\ABCDEFGHIJKLMNOPQRSTUVWXYZ", 8'h0D, "_ ", 8'h1B};
   localparam logic [399:0] SHIFTED_KEYS =
      {")!@#$%^&*(_+[]:\"<>?\\ABCDEFGHIJKLMNOPQRSTUVWXYZ", 8'h0D, "_ ", 8'h1B};

   typedef struct packed {
      ksr_pkg::req_type poll;
      bit               typed;
      ksr_pkg::rsp_type want;
   } plan_row_type;

   typedef struct packed {
      bit               typed;
      ksr_pkg::rsp_type want;
   } typed_note_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ksr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ksr_pkg::rsp_type rsp_data;

   logic [15:0] last_rows [4];
   logic        reset_seen;
   logic        clear_seen;

   ksr_pkg::rsp_type awaited_scans [$];
   typed_note_type   typed_notes [$];
   plan_row_type     directed_plan [$];

   int faults = 0;
   int hang_cycles = 0;
   bit calm = 1'b0;
   int ready_hold = 0;

   logic [15:0] rand_rows [4];
   logic [1:0]  rand_shift;
   logic [1:0]  rand_ctrl;
   logic        rand_rst;
   logic        rand_clr;

   keyboard_scan_rollover dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] ascii_of(input int idx, input bit ctrl, input bit shift);
      if (idx >= 50) begin
         return 8'h00;
      end
      if (ctrl) begin
         unique case (idx)
            2, 48:  return 8'h00;
            3, 12:  return 8'h1B;
            4, 19:  return 8'h1C;
            5, 13:  return 8'h1D;
            6:      return 8'h1E;
            7, 10:  return 8'h1F;
            default: begin
               if (idx >= 20 && idx <= 45) begin
                  return 8'(idx - 19);
               end
               return PLAIN_KEYS[8*(49-idx) +: 8];
            end
         endcase
      end
      if (shift) begin
         return SHIFTED_KEYS[8*(49-idx) +: 8];
      end
      return PLAIN_KEYS[8*(49-idx) +: 8];
   endfunction

   function automatic ksr_pkg::rsp_type scan_poll(input ksr_pkg::req_type p);
      ksr_pkg::rsp_type r;
      logic [15:0]      now_rows [4];
      logic [15:0]      fresh;
      logic             found;
      int               win;
      r = '0;
      found = 1'b0;
      win = 0;
      now_rows[0] = p.row0_keys;
      now_rows[1] = p.row1_keys;
      now_rows[2] = p.row2_keys;
      now_rows[3] = p.row3_keys;
      r.pia_reset_pulse    = p.reset_button && !reset_seen;
      r.clear_screen_pulse = p.clear_button && !clear_seen;
      reset_seen = p.reset_button;
      clear_seen = p.clear_button;
      for (int i = 0; i < 4; i++) begin
         fresh = now_rows[i] & ~last_rows[i];
         for (int b = 0; b < 16; b++) begin
            if (fresh[b]) begin
               found = 1'b1;
               win = i * 16 + b;
            end
         end
         last_rows[i] = now_rows[i];
      end
      r.port_a_value = (found ? ascii_of(win, |p.ctrl_bits, |p.shift_bits) : 8'h00)
                       | ksr_pkg::CODE_FLAG;
      r.key_strobe           = found;
      r.cpu_reset_hold       = reset_seen;
      r.video_writes_ignored = clear_seen;
      return r;
   endfunction

   function automatic ksr_pkg::req_type mk_poll(input logic [15:0] r0, input logic [15:0] r1,
                                                input logic [15:0] r2, input logic [15:0] r3,
                                                input logic [1:0] sh, input logic [1:0] ct,
                                                input logic rb, input logic cb);
      ksr_pkg::req_type p;
      p.row0_keys    = r0;
      p.row1_keys    = r1;
      p.row2_keys    = r2;
      p.row3_keys    = r3;
      p.shift_bits   = sh;
      p.ctrl_bits    = ct;
      p.reset_button = rb;
      p.clear_button = cb;
      return p;
   endfunction

   function automatic ksr_pkg::rsp_type mk_scan(input logic [7:0] code, input logic strobe,
                                                input logic rh, input logic rp,
                                                input logic cp, input logic vw);
      ksr_pkg::rsp_type r;
      r.port_a_value         = code;
      r.key_strobe           = strobe;
      r.cpu_reset_hold       = rh;
      r.pia_reset_pulse      = rp;
      r.clear_screen_pulse   = cp;
      r.video_writes_ignored = vw;
      return r;
   endfunction

   task automatic add_row(input ksr_pkg::req_type p, input bit typed,
                          input ksr_pkg::rsp_type w);
      plan_row_type row;
      row.poll  = p;
      row.typed = typed;
      row.want  = w;
      directed_plan.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         faults++;
      end
   endtask

   task automatic send_poll(input ksr_pkg::req_type p, input bit typed,
                            input ksr_pkg::rsp_type w);
      typed_note_type note;
      int             gap;
      note.typed = typed;
      note.want  = w;
      typed_notes.push_back(note);
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic next_random_poll(output ksr_pkg::req_type p);
      int mode;
      int n;
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            rand_rows[$urandom_range(0, 3)][$urandom_range(0, 15)] ^= 1'b1;
         end
      end else if (mode < 70) begin
         foreach (rand_rows[i]) rand_rows[i] = '0;
         rand_rows[$urandom_range(0, 3)][$urandom_range(0, 15)] = 1'b1;
      end else if (mode < 85) begin
         foreach (rand_rows[i]) rand_rows[i] = 16'($urandom);
      end else if (mode < 93) begin
         foreach (rand_rows[i]) rand_rows[i] = '0;
      end
      rand_shift = ($urandom_range(0, 9) < 3) ? 2'($urandom_range(1, 3)) : 2'b00;
      rand_ctrl  = ($urandom_range(0, 9) < 3) ? 2'($urandom_range(1, 3)) : 2'b00;
      if ($urandom_range(0, 7) == 0) rand_rst = ~rand_rst;
      if ($urandom_range(0, 7) == 0) rand_clr = ~rand_clr;
      p = mk_poll(rand_rows[0], rand_rows[1], rand_rows[2], rand_rows[3],
                  rand_shift, rand_ctrl, rand_rst, rand_clr);
   endtask

   // Hold result ready low in random bursts.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         ready_hold <= $urandom_range(0, 16);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : scan_monitor
      typed_note_type   note;
      ksr_pkg::rsp_type model;
      ksr_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_scans.size() == 0) begin
               $display("%0t ns: result beat with none expected, actual %0h", $time, rsp_data);
               faults++;
            end else begin
               want = awaited_scans.pop_front();
               check_field("port_a_value", want.port_a_value, rsp_data.port_a_value);
               check_field("key_strobe", 8'(want.key_strobe), 8'(rsp_data.key_strobe));
               check_field("cpu_reset_hold", 8'(want.cpu_reset_hold),
                           8'(rsp_data.cpu_reset_hold));
               check_field("pia_reset_pulse", 8'(want.pia_reset_pulse),
                           8'(rsp_data.pia_reset_pulse));
               check_field("clear_screen_pulse", 8'(want.clear_screen_pulse),
                           8'(rsp_data.clear_screen_pulse));
               check_field("video_writes_ignored", 8'(want.video_writes_ignored),
                           8'(rsp_data.video_writes_ignored));
            end
         end
         if (req_valid && req_ready) begin
            note  = typed_notes.pop_front();
            model = scan_poll(req_data);
            awaited_scans.push_back(note.typed ? note.want : model);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         hang_cycles <= 0;
      end else begin
         hang_cycles <= hang_cycles + 1;
         if (hang_cycles + 1 >= HANG_LIMIT) begin
            $display("%0t ns: watchdog, no beat for %0d cycles", $time, HANG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      ksr_pkg::req_type p;
      foreach (last_rows[i]) last_rows[i] = '0;
      foreach (rand_rows[i]) rand_rows[i] = '0;
      reset_seen = 1'b0;
      clear_seen = 1'b0;
      rand_rst = 1'b0;
      rand_clr = 1'b0;

      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 1,
              mk_scan(8'h80, 0, 0, 0, 0, 0));
      add_row(mk_poll(16'h0001, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 1,
              mk_scan(8'hB0, 1, 0, 0, 0, 0));
      add_row(mk_poll(16'h0001, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 1,
              mk_scan(8'h80, 0, 0, 0, 0, 0));
      add_row(mk_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'b00, 2'b00, 0, 0), 1,
              mk_scan(8'h80, 1, 0, 0, 0, 0));
      add_row(mk_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'b11, 2'b11, 1, 0), 1,
              mk_scan(8'h80, 0, 1, 1, 0, 0));
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 1, 1), 1,
              mk_scan(8'h80, 0, 1, 0, 1, 1));
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 1), 1,
              mk_scan(8'h80, 0, 0, 0, 0, 1));
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 1,
              mk_scan(8'h80, 0, 0, 0, 0, 0));
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0002, 2'b00, 2'b00, 0, 0), 1,
              mk_scan(8'h9B, 1, 0, 0, 0, 0));
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0006, 2'b00, 2'b00, 0, 0), 1,
              mk_scan(8'h80, 1, 0, 0, 0, 0));
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0010, 16'h0, 16'h0, 2'b00, 2'b01, 0, 0), 1,
              mk_scan(8'h81, 1, 0, 0, 0, 0));
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h0004, 16'h0, 16'h0, 16'h0, 2'b10, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h0004, 16'h0, 16'h0, 16'h0, 2'b11, 2'b01, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h8000, 16'h0001, 16'h0040, 16'h0, 2'b00, 2'b10, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0001, 2'b00, 2'b10, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h4001, 2'b01, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0, 16'h4000, 16'h0, 2'b01, 2'b00, 0, 0), 0, '0);
      add_row(mk_poll(16'h0, 16'h0, 16'h0, 16'h0, 2'b00, 2'b00, 1, 0), 0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         send_poll(directed_plan[i].poll, directed_plan[i].typed, directed_plan[i].want);
      end

      for (int n = 0; n < RANDOM_POLLS; n++) begin
         if (n == RANDOM_POLLS - CALM_POLLS) calm = 1'b1;
         next_random_poll(p);
         send_poll(p, 1'b0, '0);
      end
      req_valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (awaited_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (faults == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
